FILE: src/xml_entity_decoder_unit_macros.svh
// assertion macros shared by the entity decoder checker
`ifndef XML_ENTITY_DECODER_UNIT_MACROS_SVH
`define XML_ENTITY_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define XED_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("xml entity decoder check failed");

// next-cycle implication, checked outside reset
`define XED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("xml entity decoder check failed");

`endif

FILE: src/xed_pkg.sv
// types, constants and name tables of the xml entity decoder
package xed_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned ACC_W       = 21;
  localparam int unsigned NUM_RES     = 4;

  localparam logic [ACC_W-1:0] CODE_LIMIT = 21'h110000;
  localparam logic [ACC_W-1:0] ACC_SAT    = 21'h1FFFFF;
  localparam logic [ACC_W-1:0] LIM_1BYTE  = 21'h000080;
  localparam logic [ACC_W-1:0] LIM_2BYTE  = 21'h000800;
  localparam logic [ACC_W-1:0] LIM_3BYTE  = 21'h010000;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] NBSP_HI    = 8'hC2;
  localparam logic [7:0] NBSP_LO    = 8'hA0;

  // scan mode, one-hot
  typedef enum logic [12:0] {
    MODE_PLAIN   = 13'b0000000000001,
    MODE_AMP     = 13'b0000000000010,
    MODE_A       = 13'b0000000000100,
    MODE_AMPN    = 13'b0000000001000,
    MODE_APOS    = 13'b0000000010000,
    MODE_QUOT    = 13'b0000000100000,
    MODE_GT      = 13'b0000001000000,
    MODE_LT      = 13'b0000010000000,
    MODE_NBSP    = 13'b0000100000000,
    MODE_HASH    = 13'b0001000000000,
    MODE_DEC     = 13'b0010000000000,
    MODE_HEX     = 13'b0100000000000,
    MODE_DISCARD = 13'b1000000000000
  } mode_e;

  typedef struct packed {
    logic       last_of_run;
    logic       end_of_string;
    logic       decode_error;
    logic       out_valid;
    logic [7:0] out_byte;
  } res_t;

  function automatic res_t mk_res(logic [7:0] b, logic v, logic e);
    res_t r;
    r.out_byte      = b;
    r.out_valid     = v;
    r.decode_error  = e;
    r.end_of_string = 1'b0;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // characters of a name still to match after its leading letters
  function automatic logic [2:0] name_len(mode_e m);
    logic [2:0] l;
    unique case (m)
      MODE_AMPN, MODE_GT, MODE_LT: l = 3'd2;
      MODE_APOS:                   l = 3'd3;
      MODE_QUOT, MODE_NBSP:        l = 3'd4;
      default:                     l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] name_char(mode_e m, logic [2:0] p);
    logic [31:0] s;
    unique case (m)
      MODE_AMPN: s = {"p;", 16'h0};
      MODE_APOS: s = {"os;", 8'h0};
      MODE_QUOT: s = "uot;";
      MODE_GT:   s = {"t;", 16'h0};
      MODE_LT:   s = {"t;", 16'h0};
      MODE_NBSP: s = "bsp;";
      default:   s = 32'h0;
    endcase
    unique case (p)
      3'd0:    return s[31:24];
      3'd1:    return s[23:16];
      3'd2:    return s[15:8];
      3'd3:    return s[7:0];
      default: return 8'h0;
    endcase
  endfunction

  // single replacement byte of the short names (nbsp handled apart)
  function automatic logic [7:0] name_byte(mode_e m);
    logic [7:0] b;
    unique case (m)
      MODE_AMPN: b = "&";
      MODE_APOS: b = "'";
      MODE_QUOT: b = "\"";
      MODE_GT:   b = ">";
      MODE_LT:   b = "<";
      default:   b = 8'h0;
    endcase
    return b;
  endfunction

endpackage

FILE: src/xml_entity_decoder_unit.sv
// xml attribute value entity decoder with utf-8 output, stream in and out
//
// input channel s_axis: one word per string byte, tdata = data_byte, tlast
// marks the final byte of a string. output channel m_axis: one word per
// decoded byte or status; tdata carries out_byte and last_of_run, tuser the
// flags out_valid and decode_error, tlast marks end_of_string.
// named entities become one byte (nbsp two), &#N; and &#xH; become one to
// four utf-8 bytes. a malformed or out-of-range entity gives one error word
// and the rest of the string is dropped; the last byte then closes the
// string with an error status word.
// a word accepted on s_axis is held in the input register, decoded from
// there, and its results are loaded into the result buffer that drives m_axis.
// throughput: one input word per cycle while each word yields at most one
// result and m_axis_tready_i stays high; a word that yields more results
// holds the four-entry result buffer until they have left, and the input side waits.
// the result buffer is loaded only when it is empty or empties in the same cycle.
// reset: both buffers empty, decoder back in plain text mode.
// stall: a waiting result holds steady; the input register takes one more
// word, after which s_axis_tready_o drops until the buffer drains.
module xml_entity_decoder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [xed_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,   // [7:0] data_byte
  input  logic                                 s_axis_tlast_i,   // last_byte
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [xed_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,   // [7:0] out_byte, [8] last_of_run
  output logic [xed_pkg::OUT_TUSER_W-1:0]      m_axis_tuser_o,   // [0] out_valid, [1] decode_error
  output logic                                 m_axis_tlast_o    // end_of_string
);

  // input register
  logic                          in_valid_q, in_valid_d;
  logic [7:0]                    in_data_q;
  logic                          in_last_q;

  // decoder state
  xed_pkg::mode_e                mode_q, mode_d;
  logic [2:0]                    pos_q, pos_d;
  logic [xed_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic                          ovf_q, ovf_d;

  // result buffer, entry 0 faces the output
  xed_pkg::res_t                 res_q [xed_pkg::NUM_RES];
  xed_pkg::res_t                 res_w [xed_pkg::NUM_RES];
  logic [2:0]                    cnt_q, cnt_d;
  logic [2:0]                    n_w;

  logic                          s_accept, pop, load;

  // decode helpers
  logic [7:0]                    b;
  logic                          is_dec, is_hex;
  logic [3:0]                    dval;
  logic                          use_hex;
  logic [xed_pkg::ACC_W+4:0]     acc_next;
  logic [xed_pkg::ACC_W-1:0]     c;
  logic [1:0]                    last_idx;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign pop      = m_axis_tvalid_o && m_axis_tready_i;
  // buffer takes a new run only when it is empty or loses its last entry now
  assign load     = in_valid_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && pop));
  assign s_axis_tready_o = !in_valid_q || load;

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = {{(xed_pkg::OUT_TDATA_W-9){1'b0}}, res_q[0].last_of_run,
                            res_q[0].out_byte};
  assign m_axis_tuser_o  = {res_q[0].decode_error, res_q[0].out_valid};
  assign m_axis_tlast_o  = res_q[0].end_of_string;

  // digit classification
  assign b      = in_data_q;
  assign is_dec = (b >= "0") && (b <= "9");
  assign is_hex = is_dec || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  always_comb begin
    if (is_dec) begin
      dval = 4'(b - "0");
    end else if ((b >= "a") && (b <= "f")) begin
      dval = 4'(b - "a" + 8'd10);
    end else begin
      dval = 4'(b - "A" + 8'd10);
    end
  end

  // accumulator times base plus digit, base 10 as shift and add
  assign use_hex  = (mode_q == xed_pkg::MODE_HEX);
  assign acc_next = use_hex
      ? ({1'b0, acc_q, 4'b0} + 26'(dval))
      : (26'({acc_q, 3'b0}) + 26'({acc_q, 1'b0}) + 26'(dval));
  assign c = acc_q;

  // single pass decode of the registered word
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    n_w    = 3'd0;
    for (int i = 0; i < xed_pkg::NUM_RES; i++) begin
      res_w[i] = xed_pkg::mk_res(8'h0, 1'b0, 1'b0);
    end

    unique case (mode_q)
      xed_pkg::MODE_PLAIN: begin
        if (b == "&") begin
          mode_d = xed_pkg::MODE_AMP;
        end else begin
          res_w[0] = xed_pkg::mk_res(b, 1'b1, 1'b0);
          n_w      = 3'd1;
        end
      end
      xed_pkg::MODE_AMP: begin
        pos_d = 3'd0;
        priority if (b == "a") begin
          mode_d = xed_pkg::MODE_A;
          pos_d  = pos_q;
        end else if (b == "q") begin
          mode_d = xed_pkg::MODE_QUOT;
        end else if (b == "g") begin
          mode_d = xed_pkg::MODE_GT;
        end else if (b == "l") begin
          mode_d = xed_pkg::MODE_LT;
        end else if (b == "n") begin
          mode_d = xed_pkg::MODE_NBSP;
        end else if (b == "#") begin
          mode_d = xed_pkg::MODE_HASH;
          pos_d  = pos_q;
          acc_d  = '0;
          ovf_d  = 1'b0;
        end else begin
          pos_d    = pos_q;
          mode_d   = xed_pkg::MODE_DISCARD;
          res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
          n_w      = 3'd1;
        end
      end
      xed_pkg::MODE_A: begin
        priority if (b == "m") begin
          mode_d = xed_pkg::MODE_AMPN;
          pos_d  = 3'd0;
        end else if (b == "p") begin
          mode_d = xed_pkg::MODE_APOS;
          pos_d  = 3'd0;
        end else begin
          mode_d   = xed_pkg::MODE_DISCARD;
          res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
          n_w      = 3'd1;
        end
      end
      xed_pkg::MODE_AMPN, xed_pkg::MODE_APOS, xed_pkg::MODE_QUOT,
      xed_pkg::MODE_GT, xed_pkg::MODE_LT, xed_pkg::MODE_NBSP: begin
        if ((pos_q >= xed_pkg::name_len(mode_q)) ||
            (b != xed_pkg::name_char(mode_q, pos_q))) begin
          mode_d   = xed_pkg::MODE_DISCARD;
          res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
          n_w      = 3'd1;
        end else if ((pos_q + 3'd1) < xed_pkg::name_len(mode_q)) begin
          pos_d = pos_q + 3'd1;
        end else begin
          // name complete
          mode_d = xed_pkg::MODE_PLAIN;
          pos_d  = 3'd0;
          if (mode_q == xed_pkg::MODE_NBSP) begin
            res_w[0] = xed_pkg::mk_res(xed_pkg::NBSP_HI, 1'b1, 1'b0);
            res_w[1] = xed_pkg::mk_res(xed_pkg::NBSP_LO, 1'b1, 1'b0);
            n_w      = 3'd2;
          end else begin
            res_w[0] = xed_pkg::mk_res(xed_pkg::name_byte(mode_q), 1'b1, 1'b0);
            n_w      = 3'd1;
          end
        end
      end
      xed_pkg::MODE_HASH, xed_pkg::MODE_DEC, xed_pkg::MODE_HEX: begin
        priority if ((mode_q == xed_pkg::MODE_HASH) && (b == "x")) begin
          mode_d = xed_pkg::MODE_HEX;
        end else if (use_hex ? is_hex : is_dec) begin
          if (!use_hex) begin
            mode_d = xed_pkg::MODE_DEC;
          end
          // saturate once the code leaves the unicode range
          if (!ovf_q) begin
            if (acc_next >= 26'(xed_pkg::CODE_LIMIT)) begin
              ovf_d = 1'b1;
              acc_d = xed_pkg::ACC_SAT;
            end else begin
              acc_d = acc_next[xed_pkg::ACC_W-1:0];
            end
          end
        end else if (b == ";") begin
          mode_d = xed_pkg::MODE_PLAIN;
          priority if (ovf_q || (c >= xed_pkg::CODE_LIMIT)) begin
            mode_d   = xed_pkg::MODE_DISCARD;
            res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
            n_w      = 3'd1;
          end else if (c < xed_pkg::LIM_1BYTE) begin
            res_w[0] = xed_pkg::mk_res(c[7:0], 1'b1, 1'b0);
            n_w      = 3'd1;
          end else if (c < xed_pkg::LIM_2BYTE) begin
            res_w[0] = xed_pkg::mk_res(xed_pkg::UTF8_LEAD2 | {3'b0, c[10:6]}, 1'b1, 1'b0);
            res_w[1] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[5:0]}, 1'b1, 1'b0);
            n_w      = 3'd2;
          end else if (c < xed_pkg::LIM_3BYTE) begin
            res_w[0] = xed_pkg::mk_res(xed_pkg::UTF8_LEAD3 | {4'b0, c[15:12]}, 1'b1, 1'b0);
            res_w[1] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[11:6]}, 1'b1, 1'b0);
            res_w[2] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[5:0]}, 1'b1, 1'b0);
            n_w      = 3'd3;
          end else begin
            res_w[0] = xed_pkg::mk_res(xed_pkg::UTF8_LEAD4 | {5'b0, c[20:18]}, 1'b1, 1'b0);
            res_w[1] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[17:12]}, 1'b1, 1'b0);
            res_w[2] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[11:6]}, 1'b1, 1'b0);
            res_w[3] = xed_pkg::mk_res(xed_pkg::UTF8_CONT | {2'b0, c[5:0]}, 1'b1, 1'b0);
            n_w      = 3'd4;
          end
        end else begin
          mode_d   = xed_pkg::MODE_DISCARD;
          res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
          n_w      = 3'd1;
        end
      end
      xed_pkg::MODE_DISCARD: begin
      end
      default: begin
        mode_d   = xed_pkg::MODE_DISCARD;
        res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
        n_w      = 3'd1;
      end
    endcase

    // end of string: a cut-off entity is an error, an empty step gets a status
    if (in_last_q) begin
      if ((mode_d != xed_pkg::MODE_PLAIN) && (mode_d != xed_pkg::MODE_DISCARD)) begin
        mode_d   = xed_pkg::MODE_DISCARD;
        res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, 1'b1);
        n_w      = 3'd1;
      end
      if (n_w == 3'd0) begin
        res_w[0] = xed_pkg::mk_res(8'h0, 1'b0, mode_d == xed_pkg::MODE_DISCARD);
        n_w      = 3'd1;
      end
    end
    last_idx = 2'(n_w - 3'd1);
    if (n_w != 3'd0) begin
      res_w[last_idx].last_of_run   = 1'b1;
      res_w[last_idx].end_of_string = in_last_q;
    end
    if (in_last_q) begin
      mode_d = xed_pkg::MODE_PLAIN;
      pos_d  = 3'd0;
      acc_d  = '0;
      ovf_d  = 1'b0;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = n_w;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= 3'd0;
      mode_q     <= xed_pkg::MODE_PLAIN;
      pos_q      <= 3'd0;
      acc_q      <= '0;
      ovf_q      <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
      if (load) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        acc_q  <= acc_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (load) begin
      for (int i = 0; i < xed_pkg::NUM_RES; i++) begin
        res_q[i] <= res_w[i];
      end
    end else if (pop) begin
      for (int i = 0; i < xed_pkg::NUM_RES - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

FILE: src/xed_checker.sv
// port-level checks of the entity decoder and their binding
`include "xml_entity_decoder_unit_macros.svh"

module xed_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [xed_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [xed_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);

  // a stalled word holds
  `XED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
  // a status word without error only closes a string
  `XED_ASSERT_IMPL(a_status_closes, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0] && !m_axis_tuser_o[1], m_axis_tlast_o)
  // the closing word is the last of its run
  `XED_ASSERT_IMPL(a_eos_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[8])
  // status words carry a zero byte
  `XED_ASSERT_IMPL(a_status_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o[7:0] == 8'h0)
  // an error word never carries a byte
  `XED_ASSERT_IMPL(a_err_no_byte, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[1], !m_axis_tuser_o[0])

endmodule

bind xml_entity_decoder_unit xed_checker u_xed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: tb/sv/xml_entity_decoder_unit_test.sv
// self-checking stream testbench for the xml entity decoder unit
module xml_entity_decoder_unit_test;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;  // [7:0] data_byte
  logic       s_axis_tlast_i  = 1'b0;   // last_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [xed_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;  // [7:0] out_byte, [8] last_of_run
  logic [xed_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o;  // [0] out_valid, [1] decode_error
  logic       m_axis_tlast_o;           // end_of_string

  xml_entity_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decoder state as the scoreboard sees it
  xed_pkg::mode_e scan_state = xed_pkg::MODE_PLAIN;
  int          name_pos   = 0;
  logic [20:0] code_acc   = '0;
  logic        code_ovf   = 1'b0;

  xed_pkg::res_t run_words[$];       // words caused by the byte in hand
  xed_pkg::res_t expected_words[$];  // decoded words still owed by the block
  xed_pkg::res_t head_word;
  logic [7:0]  pending_string[$];  // bytes of the string about to be sent

  int          mismatch_count = 0;
  int          counted_words  = 0; // input words sent so far
  bit          idling_on      = 1'b1;
  int          ready_hold     = 0;

  string entity_names[6] = '{"amp", "apos", "quot", "gt", "lt", "nbsp"};

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] result check failed: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- scoreboard

  function automatic void reset_decoder();
    scan_state = xed_pkg::MODE_PLAIN;
    name_pos   = 0;
    code_acc   = '0;
    code_ovf   = 1'b0;
  endfunction

  function automatic void put_word(input logic [7:0] b, input logic v, input logic e);
    xed_pkg::res_t w;
    w              = '0;
    w.out_byte     = b;
    w.out_valid    = v;
    w.decode_error = e;
    run_words.push_back(w);
  endfunction

  function automatic void raise_error();
    scan_state = xed_pkg::MODE_DISCARD;
    put_word(8'h00, 1'b0, 1'b1);
  endfunction

  function automatic void enter_name(input xed_pkg::mode_e m);
    scan_state = m;
    name_pos   = 0;
  endfunction

  // letters still to match once the leading letters have picked the name
  function automatic string name_tail(input xed_pkg::mode_e m);
    case (m)
      xed_pkg::MODE_AMPN: return "p;";
      xed_pkg::MODE_APOS: return "os;";
      xed_pkg::MODE_QUOT: return "uot;";
      xed_pkg::MODE_NBSP: return "bsp;";
      default:            return "t;";
    endcase
  endfunction

  function automatic logic [7:0] replacement_char(input xed_pkg::mode_e m);
    case (m)
      xed_pkg::MODE_AMPN: return "&";
      xed_pkg::MODE_APOS: return "'";
      xed_pkg::MODE_QUOT: return "\"";
      xed_pkg::MODE_GT:   return ">";
      default:            return "<";
    endcase
  endfunction

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // saturates once the code passes the unicode range
  function automatic void add_code_digit(input int base, input int d);
    logic [31:0] nxt;
    if (code_ovf) return;
    nxt = 32'(code_acc) * base + d;
    if (nxt >= 32'(xed_pkg::CODE_LIMIT)) begin
      code_ovf = 1'b1;
      code_acc = xed_pkg::ACC_SAT;
    end else begin
      code_acc = nxt[20:0];
    end
  endfunction

  function automatic void put_code();
    logic [20:0] c;
    c = code_acc;
    if (code_ovf || c >= xed_pkg::CODE_LIMIT) begin
      raise_error();
      return;
    end
    if (c < xed_pkg::LIM_1BYTE) begin
      put_word(c[7:0], 1'b1, 1'b0);
    end else if (c < xed_pkg::LIM_2BYTE) begin
      put_word(xed_pkg::UTF8_LEAD2 | 8'(c >> 6), 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[5:0]}, 1'b1, 1'b0);
    end else if (c < xed_pkg::LIM_3BYTE) begin
      put_word(xed_pkg::UTF8_LEAD3 | 8'(c >> 12), 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[11:6]}, 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[5:0]}, 1'b1, 1'b0);
    end else begin
      put_word(xed_pkg::UTF8_LEAD4 | 8'(c >> 18), 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[17:12]}, 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[11:6]}, 1'b1, 1'b0);
      put_word(xed_pkg::UTF8_CONT | {2'b00, c[5:0]}, 1'b1, 1'b0);
    end
    scan_state = xed_pkg::MODE_PLAIN;
  endfunction

  // works out the words one accepted byte must produce, in order
  function automatic void decode_entity_byte(input logic [7:0] b, input logic last);
    string         tail;
    int            d;
    xed_pkg::res_t w;
    run_words.delete();
    case (scan_state)
      xed_pkg::MODE_PLAIN: begin
        if (b == "&") scan_state = xed_pkg::MODE_AMP;
        else put_word(b, 1'b1, 1'b0);
      end
      xed_pkg::MODE_AMP: begin
        case (b)
          "a": scan_state = xed_pkg::MODE_A;
          "q": enter_name(xed_pkg::MODE_QUOT);
          "g": enter_name(xed_pkg::MODE_GT);
          "l": enter_name(xed_pkg::MODE_LT);
          "n": enter_name(xed_pkg::MODE_NBSP);
          "#": begin
            scan_state = xed_pkg::MODE_HASH;
            code_acc   = '0;
            code_ovf   = 1'b0;
          end
          default: raise_error();
        endcase
      end
      xed_pkg::MODE_A: begin
        if (b == "m") enter_name(xed_pkg::MODE_AMPN);
        else if (b == "p") enter_name(xed_pkg::MODE_APOS);
        else raise_error();
      end
      xed_pkg::MODE_AMPN, xed_pkg::MODE_APOS, xed_pkg::MODE_QUOT,
      xed_pkg::MODE_GT, xed_pkg::MODE_LT, xed_pkg::MODE_NBSP: begin
        tail = name_tail(scan_state);
        if (b != tail[name_pos]) begin
          raise_error();
        end else begin
          name_pos++;
          if (name_pos == tail.len()) begin
            if (scan_state == xed_pkg::MODE_NBSP) begin
              put_word(xed_pkg::NBSP_HI, 1'b1, 1'b0);
              put_word(xed_pkg::NBSP_LO, 1'b1, 1'b0);
            end else begin
              put_word(replacement_char(scan_state), 1'b1, 1'b0);
            end
            enter_name(xed_pkg::MODE_PLAIN);
          end
        end
      end
      xed_pkg::MODE_HASH, xed_pkg::MODE_DEC: begin
        if (scan_state == xed_pkg::MODE_HASH && b == "x") begin
          scan_state = xed_pkg::MODE_HEX;
        end else if (b >= "0" && b <= "9") begin
          scan_state = xed_pkg::MODE_DEC;
          add_code_digit(10, int'(b - "0"));
        end else if (b == ";") begin
          put_code();
        end else begin
          raise_error();
        end
      end
      xed_pkg::MODE_HEX: begin
        d = hex_value(b);
        if (d >= 0) add_code_digit(16, d);
        else if (b == ";") put_code();
        else raise_error();
      end
      xed_pkg::MODE_DISCARD: ;
      default: raise_error();
    endcase

    // the last byte always closes the string and rewinds the decoder
    if (last) begin
      if (scan_state != xed_pkg::MODE_PLAIN && scan_state != xed_pkg::MODE_DISCARD)
        raise_error();
      if (run_words.size() == 0)
        put_word(8'h00, 1'b0, scan_state == xed_pkg::MODE_DISCARD);
      w = run_words.pop_back();
      w.end_of_string = 1'b1;
      run_words.push_back(w);
      reset_decoder();
    end
    if (run_words.size() > 0) begin
      w = run_words.pop_back();
      w.last_of_run = 1'b1;
      run_words.push_back(w);
    end
    foreach (run_words[i]) expected_words.push_back(run_words[i]);
  endfunction

  // ---------------------------------------------------------------- output side

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                  m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o));
      end else begin
        head_word = expected_words.pop_front();
        if (m_axis_tdata_o[7:0] !== head_word.out_byte)
          report_mismatch($sformatf("out_byte %h, wanted %h",
                                    m_axis_tdata_o[7:0], head_word.out_byte));
        if (m_axis_tuser_o[0] !== head_word.out_valid)
          report_mismatch($sformatf("out_valid %b, wanted %b",
                                    m_axis_tuser_o[0], head_word.out_valid));
        if (m_axis_tuser_o[1] !== head_word.decode_error)
          report_mismatch($sformatf("decode_error %b, wanted %b",
                                    m_axis_tuser_o[1], head_word.decode_error));
        if (m_axis_tlast_o !== head_word.end_of_string)
          report_mismatch($sformatf("end_of_string %b, wanted %b",
                                    m_axis_tlast_o, head_word.end_of_string));
        if (m_axis_tdata_o[8] !== head_word.last_of_run)
          report_mismatch($sformatf("last_of_run %b, wanted %b",
                                    m_axis_tdata_o[8], head_word.last_of_run));
      end
    end
    // back-pressure in random bursts
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (idling_on && rst_ni && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(1, 14) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- input side

  // tvalid stays high from one word to the next unless a gap is taken
  task automatic send_word(input logic [7:0] b, input logic last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    counted_words++;
    decode_entity_byte(b, last);
  endtask

  task automatic send_pending_string();
    for (int i = 0; i < pending_string.size(); i++)
      send_word(pending_string[i], i == pending_string.size() - 1);
    pending_string.delete();
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_string.push_back(s[i]);
  endtask

  // named entity; a broken one has one letter or the semicolon replaced
  task automatic append_named(input bit broken, input bit cut_off);
    string full;
    int    spoilt;
    int    keep;
    full   = {"&", entity_names[$urandom_range(0, 5)], ";"};
    spoilt = broken ? $urandom_range(1, full.len() - 1) : -1;
    keep   = cut_off ? $urandom_range(1, full.len() - 1) : full.len();
    for (int i = 0; i < keep; i++) begin
      if (i == spoilt) pending_string.push_back(8'($urandom_range(0, 255)));
      else pending_string.push_back(full[i]);
    end
  endtask

  // numeric reference across all utf-8 lengths, the range edge and beyond
  task automatic append_reference(input bit broken);
    logic [31:0] code;
    string       digits;
    bit          use_hex;
    case ($urandom_range(0, 9))
      0, 1:    code = $urandom_range(0, 32'h7F);
      2, 3:    code = $urandom_range(32'h80, 32'h7FF);
      4, 5:    code = $urandom_range(32'h800, 32'hFFFF);
      6, 7:    code = $urandom_range(32'h10000, 32'h10FFFF);
      8:       code = $urandom_range(32'h110000, 32'hFFFFFF);
      default: code = 32'h10FFFF + $urandom_range(0, 1);
    endcase
    use_hex = $urandom_range(0, 1);
    digits  = use_hex ? $sformatf("%0h", code) : $sformatf("%0d", code);
    if ($urandom_range(0, 9) == 0) digits = {"0", digits};
    if ($urandom_range(0, 15) == 0) digits = "";
    append_text(use_hex ? "&#x" : "&#");
    for (int i = 0; i < digits.len(); i++) begin
      if (digits[i] >= "a" && $urandom_range(0, 1) == 1)
        pending_string.push_back(digits[i] - 8'd32);
      else
        pending_string.push_back(digits[i]);
    end
    if (broken) pending_string.push_back(8'($urandom_range(0, 255)));
    else pending_string.push_back(";");
  endtask

  // mostly well-formed text with some noise and broken entities mixed in
  task automatic build_random_string();
    int  pieces;
    bit  cut_off;
    pieces  = $urandom_range(1, 8);
    cut_off = 1'b0;
    for (int p = 0; p < pieces && !cut_off; p++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          repeat ($urandom_range(1, 4)) pending_string.push_back(8'($urandom_range(0, 255)));
        end
        7, 8, 9, 10, 11:     append_named(1'b0, 1'b0);
        12, 13, 14, 15, 16:  append_reference(1'b0);
        17: begin
          if ($urandom_range(0, 1) == 1) append_named(1'b1, 1'b0);
          else append_reference(1'b1);
        end
        18: begin
          pending_string.push_back("&");
          pending_string.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          append_named(1'b0, 1'b1);
          cut_off = 1'b1;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_byte_extremes();
    pending_string.push_back(8'h00);
    pending_string.push_back(8'hFF);
    send_pending_string();
  endtask

  task automatic test_nbsp_entity();
    append_text("&nbsp;");
    send_pending_string();
  endtask

  task automatic test_four_byte_reference();
    append_text("&#x1F600;");
    send_pending_string();
  endtask

  task automatic test_empty_reference();
    append_text("&#;");
    send_pending_string();
  endtask

  // error, then a discarded byte, then the closing error status
  task automatic test_unknown_letter();
    append_text("&zw");
    send_pending_string();
  endtask

  task automatic test_cut_off_entity();
    append_text("&lt");
    send_pending_string();
  endtask

  task automatic test_random_strings();
    while (counted_words < 200) begin
      idling_on = counted_words < 170;
      build_random_string();
      if (pending_string.size() == 0) pending_string.push_back(8'($urandom_range(0, 255)));
      send_pending_string();
      // sender holds off now and then until the block has caught up
      if ($urandom_range(0, 7) == 0) wait_until_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_byte_extremes();
    test_nbsp_entity();
    test_four_byte_reference();
    test_empty_reference();
    test_unknown_letter();
    test_cut_off_entity();
    wait_until_drained();
    test_random_strings();
    wait_until_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
